// File: src/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg: shared types and constants for the timestamp reorder buffer
// Word layouts, command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int STAMP_W = 64;
    localparam int TAG_W   = 32;
    localparam int CFG_W   = 5;
    localparam int OCC_W   = 5;
    localparam int CFG_IDX_W = 1;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_POPPED  = 2'd2;
    localparam logic [1:0] ST_NOT_RDY = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL = 1'd1;

    localparam logic [CFG_W-1:0] CAPACITY_RST = 5'd10;
    localparam logic [CFG_W-1:0] MIN_FILL_RST = 5'd3;

    typedef struct packed {
        logic               command;
        logic [STAMP_W-1:0] stamp_us;
        logic [TAG_W-1:0]   frame_tag;
        logic               drain;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [STAMP_W-1:0] out_stamp_us;
        logic [TAG_W-1:0]   out_frame_tag;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic first;
    } scan_ctl_t;

endpackage

// File: src/trb_min_unit.sv
// ----------------------------------------------------------------------------
// trb_min_unit: running minimum over a stream of entries
// One 64-bit compare per cycle; strict less-than keeps the earliest on ties.
// ----------------------------------------------------------------------------
module trb_min_unit #(
    parameter int IW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  trb_pkg::scan_ctl_t ctl,
    input  trb_pkg::entry_t   entry,
    input  logic [IW-1:0]     idx,
    output trb_pkg::entry_t   best,
    output logic [IW-1:0]     best_idx
);

    trb_pkg::entry_t best_reg;
    logic [IW-1:0]   best_idx_reg;
    logic            take;

    assign take = ctl.valid && (ctl.first || (entry.stamp < best_reg.stamp));

    // payload only, first entry of a scan always loads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg     <= entry;
            best_idx_reg <= idx;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

    a_first_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid && ctl.first |=> best_idx_reg == $past(idx))
        else $error("scan start did not load the minimum");

    a_no_raise: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid && !ctl.first |=> best_reg.stamp <= $past(best_reg.stamp))
        else $error("running minimum increased");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.valid |=> $stable(best_idx_reg))
        else $error("minimum changed without a valid entry");

endmodule

// File: src/timestamp_reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer_unit: timestamp-ordered frame reorder buffer
// Holds frames in arrival order; pop returns the smallest timestamp.
//
//   channel   ports                       direction  handshake
//   command   start, busy, req            in         start & !busy
//   result    done, rsp                   out        done strobe, one cycle
//   config    cfg_we, cfg_idx, cfg_data   in         cfg_we
//
// Push, refused push and a pop with nothing ready: result in the cycle after
// the command, block stays ready. Pop that releases: busy through the min
// scan (S_SCAN, S_SCAN_END), S_PICK and the gap close (S_SHIFT); the result
// is shown as the block turns idle. The entry memory has a single read port:
// one read per cycle for the min scan, then one per cycle to close the gap.
// Reset clears occupancy and loads the register defaults; no clearing pass.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module timestamp_reorder_buffer_unit #(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  trb_pkg::req_t                  req,
    output logic                           done,
    output trb_pkg::rsp_t                  rsp,
    input  logic                           cfg_we,
    input  logic [trb_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [trb_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CFG_W = trb_pkg::CFG_W;
    localparam int OCC_W = trb_pkg::OCC_W;
    localparam int WW    = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SCAN_END = 3'd2;
    localparam logic [2:0] S_PICK     = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    src_reg, src_next;
    logic             scan_vld_reg, scan_vld_next;
    logic [IW-1:0]    scan_idx_reg;
    logic             mv_vld_reg, mv_vld_next;
    logic [IW-1:0]    mv_dst_reg, mv_dst_next;
    logic             done_reg, done_next;
    trb_pkg::rsp_t    rsp_reg, rsp_next;
    logic [CFG_W-1:0] cap_reg, min_reg;

    trb_pkg::entry_t  mem [DEPTH];
    trb_pkg::entry_t  rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    trb_pkg::entry_t  mem_wdata;

    logic [WW-1:0]    min_w, cap_w, eff_min, cap_sat, eff_cap, cnt_w, depth_w;
    logic [IW-1:0]    last_idx;
    logic             accept, push_ok, pop_rdy;

    trb_pkg::scan_ctl_t scan_ctl;
    trb_pkg::entry_t    best;
    logic [IW-1:0]      best_idx;

    // effective limits
    always_comb
    begin
        depth_w = WW'(DEPTH);
        min_w   = WW'(min_reg);
        cap_w   = WW'(cap_reg);
        cnt_w   = WW'(cnt_reg);
        if (min_w == '0)
            eff_min = WW'(1);
        else if (min_w > depth_w)
            eff_min = depth_w;
        else
            eff_min = min_w;
        cap_sat = (cap_w > depth_w) ? depth_w : cap_w;
        eff_cap = (cap_sat < eff_min) ? eff_min : cap_sat;
    end

    assign accept   = start && (state_reg == S_IDLE);
    assign push_ok  = (cnt_w < eff_cap) && (cnt_w < depth_w);
    assign pop_rdy  = (cnt_reg != '0) && (req.drain || (cnt_w >= eff_min));
    assign last_idx = IW'(cnt_reg - CW'(1));
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        src_next      = src_reg;
        scan_vld_next = 1'b0;
        mv_vld_next   = 1'b0;
        mv_dst_next   = mv_dst_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        rd_addr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next              = 1'b1;
                    rsp_next.out_stamp_us  = '0;
                    rsp_next.out_frame_tag = '0;
                    rsp_next.occupancy     = OCC_W'(cnt_reg);
                    if (req.command == trb_pkg::CMD_PUSH)
                    begin
                        if (push_ok)
                        begin
                            cnt_next           = cnt_reg + CW'(1);
                            rsp_next.status    = trb_pkg::ST_PUSHED;
                            rsp_next.occupancy = OCC_W'(cnt_reg + CW'(1));
                        end
                        else
                        begin
                            rsp_next.status = trb_pkg::ST_FULL;
                        end
                    end
                    else if (pop_rdy)
                    begin
                        done_next  = 1'b0;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        rsp_next.status = trb_pkg::ST_NOT_RDY;
                    end
                end
            end
            S_SCAN:
            begin
                rd_addr       = idx_reg;
                scan_vld_next = 1'b1;
                if (idx_reg == last_idx)
                    state_next = S_SCAN_END;
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_SCAN_END:
            begin
                // last compare lands this cycle
                state_next = S_PICK;
            end
            S_PICK:
            begin
                src_next   = CW'(best_idx) + CW'(1);
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (src_reg < cnt_reg)
                begin
                    // read entry above the gap, write it one down next cycle
                    rd_addr     = src_reg[IW-1:0];
                    mv_vld_next = 1'b1;
                    mv_dst_next = IW'(src_reg - CW'(1));
                    src_next    = src_reg + CW'(1);
                end
                else
                begin
                    cnt_next               = cnt_reg - CW'(1);
                    done_next              = 1'b1;
                    rsp_next.status        = trb_pkg::ST_POPPED;
                    rsp_next.out_stamp_us  = best.stamp;
                    rsp_next.out_frame_tag = best.tag;
                    rsp_next.occupancy     = OCC_W'(cnt_reg - CW'(1));
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            scan_vld_reg <= 1'b0;
            mv_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
            cap_reg      <= trb_pkg::CAPACITY_RST;
            min_reg      <= trb_pkg::MIN_FILL_RST;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            scan_vld_reg <= scan_vld_next;
            mv_vld_reg   <= mv_vld_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    trb_pkg::REG_CAPACITY: cap_reg <= cfg_data;
                    trb_pkg::REG_MIN_FILL: min_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        src_reg      <= src_next;
        scan_idx_reg <= idx_reg;
        mv_dst_reg   <= mv_dst_next;
        rsp_reg      <= rsp_next;
    end

    // entry memory: one write, one registered read per cycle
    assign mem_we    = mv_vld_reg ||
                       (accept && (req.command == trb_pkg::CMD_PUSH) && push_ok);
    assign mem_waddr = mv_vld_reg ? mv_dst_reg : cnt_reg[IW-1:0];
    assign mem_wdata = mv_vld_reg ? rd_data_reg
                                  : trb_pkg::entry_t'{stamp: req.stamp_us,
                                                      tag:   req.frame_tag};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    assign scan_ctl.valid = scan_vld_reg;
    assign scan_ctl.first = (scan_idx_reg == '0);

    trb_min_unit #(
        .IW (IW)
    ) u_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .entry    (rd_data_reg),
        .idx      (scan_idx_reg),
        .best     (best),
        .best_idx (best_idx)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.command == trb_pkg::CMD_PUSH) |=> done)
        else $error("push result missing");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == trb_pkg::ST_POPPED) |->
            CW'(cnt_reg + CW'(1)) == $past(cnt_reg))
        else $error("pop did not drop occupancy by one");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) || (state_reg == S_SCAN_END) |-> !mem_we)
        else $error("memory written during scan");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result shown while busy");

endmodule
